### hw/rtl/mfq_pkg.sv
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared constants, codes and types of the three-level feedback queue
// scheduler: field widths, status and outcome codes, queue entry layout and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mfq_pkg;

  // Sizing.
  localparam int MAX_PROCESSES = 64;
  localparam int PID_W         = $clog2(MAX_PROCESSES);
  localparam int PTR_W         = PID_W;
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int NUM_LEVELS    = 3;

  // Fixed field widths.
  localparam int LVL_W     = 2;
  localparam int TIME_W    = 16;
  localparam int CLOCK_W   = 32;
  localparam int SUM_W     = 40;
  localparam int STATUS_W  = 2;
  localparam int OUTC_W    = 2;
  localparam int PERIOD_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Input commands.
  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // Queue levels.
  localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_FCFS   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_EXTRA  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

  // Dispatch outcome codes.
  localparam logic [OUTC_W-1:0] OUTC_FINISHED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_MIDDLE   = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_PROMOTED = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_FCFS     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE_PERIOD = 2'd2;

  // Configuration reset values.
  localparam logic [TIME_W-1:0]   QUANTUM_TOP_RST    = 16'd8;
  localparam logic [TIME_W-1:0]   QUANTUM_MIDDLE_RST = 16'd16;
  localparam logic [PERIOD_W-1:0] PROMOTE_PERIOD_RST = 4'd4;

  // One queue entry.
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] orig;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;   // ready for a new item
    logic exec;   // decode: add, or select and pop a queue head
    logic apply;  // run the popped job and requeue it if unfinished
    logic sum1;   // completion sum and waiting time
    logic sum2;   // waiting sum
    logic load;   // load the result register
  } mfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic job_valid;
    logic is_add;
    logic has_job;
    logic finished;
    logic out_free;
  } mfq_stat_t;

endpackage

`default_nettype wire

### hw/rtl/mfq_job_if.sv
// ----------------------------------------------------------------------------
// mfq_job_if
// Input channel of the scheduler: one item is an add or a dispatch command.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfq_job_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [mfq_pkg::LVL_W-1:0]     level;
  logic [mfq_pkg::TIME_W-1:0]    burst;

  modport source (output valid, cmd, level, burst, input ready);
  modport sink   (input valid, cmd, level, burst, output ready);
endinterface

`default_nettype wire

### hw/rtl/mfq_result_if.sv
// ----------------------------------------------------------------------------
// mfq_result_if
// Output channel of the scheduler: one item per accepted input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfq_result_if;
  logic                           valid;
  logic                           ready;
  logic [mfq_pkg::STATUS_W-1:0]   status;
  logic [mfq_pkg::PID_W-1:0]      pid;
  logic [mfq_pkg::LVL_W-1:0]      from_level;
  logic [mfq_pkg::TIME_W-1:0]     slice_run;
  logic [mfq_pkg::TIME_W-1:0]     remaining;
  logic [mfq_pkg::OUTC_W-1:0]     outcome;
  logic [mfq_pkg::CLOCK_W-1:0]    clock_now;
  logic [mfq_pkg::SUM_W-1:0]      completion_sum;
  logic [mfq_pkg::SUM_W-1:0]      waiting_sum;
  logic [mfq_pkg::CNT_W-1:0]      process_count;
  logic                           all_empty;

  modport source (output valid, status, pid, from_level, slice_run, remaining, outcome,
                  clock_now, completion_sum, waiting_sum, process_count, all_empty,
                  input ready);
  modport sink   (input valid, status, pid, from_level, slice_run, remaining, outcome,
                  clock_now, completion_sum, waiting_sum, process_count, all_empty,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/mfq_cfg_if.sv
// ----------------------------------------------------------------------------
// mfq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mfq_pkg::CFG_IDX_W-1:0]    index;
  logic [mfq_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Three-level feedback queue scheduler: a controller and a datapath that
// holds the queue memories, the clock and the completion and waiting sums.
// ----------------------------------------------------------------------------
// The block handles one item at a time and returns exactly one result item
// for each. An add, a rejected add and a dispatch with all queues empty pass
// through decode and the result load; a dispatch that preempts its job adds
// the job run, and a dispatch that finishes its job adds the job run and the
// two accumulation steps. The job run uses the registered read of a queue
// head in the queue memory and makes the requeue write of a preempted job;
// the saturating completion and waiting sums are updated in two steps after
// the clock. The result sits in an output register, so a new item is accepted
// while the previous result waits; a stalled output adds its stall to the
// final step. Configuration writes are taken whenever reset is not held but must only be
// issued while the block is idle.
`default_nettype none

module multilevel_feedback_queue_scheduler (
  input  logic         clk,
  input  logic         rst,
  mfq_job_if.sink      job,
  mfq_result_if.source result,
  mfq_cfg_if.sink      cfg
);
  import mfq_pkg::*;

  mfq_cmd_t  cmd;
  mfq_stat_t stat;

  // Sequencing of each item.
  mfq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Queues, sums and channels.
  mfq_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .job    (job),
    .result (result),
    .cfg    (cfg)
  );

endmodule

`default_nettype wire

### hw/rtl/mfq_ctrl.sv
// ----------------------------------------------------------------------------
// mfq_ctrl
// Controller of the scheduler. Steps one item through decode, job run,
// the two accumulation steps and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  mfq_pkg::mfq_stat_t stat,
  output mfq_pkg::mfq_cmd_t  cmd
);
  import mfq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_READ   = 6'b000100,
    S_SUM1   = 6'b001000,
    S_SUM2   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.job_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.is_add && stat.has_job) state_next = S_READ;
        else                              state_next = S_RESULT;
      end
      S_READ: begin
        if (stat.finished) state_next = S_SUM1;
        else               state_next = S_RESULT;
      end
      S_SUM1: begin
        state_next = S_SUM2;
      end
      S_SUM2: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Commands to the datapath.
  always_comb begin
    cmd.idle  = (state == S_IDLE);
    cmd.exec  = (state == S_EXEC);
    cmd.apply = (state == S_READ);
    cmd.sum1  = (state == S_SUM1);
    cmd.sum2  = (state == S_SUM2);
    cmd.load  = (state == S_RESULT) && stat.out_free;
  end

endmodule

`default_nettype wire

### hw/rtl/mfq_dp.sv
// ----------------------------------------------------------------------------
// mfq_dp
// Datapath of the scheduler: the three queue memories with their pointers,
// the clock and the saturating sums, the configuration registers and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_dp (
  input  logic              clk,
  input  logic              rst,
  input  mfq_pkg::mfq_cmd_t cmd,
  output mfq_pkg::mfq_stat_t stat,
  mfq_job_if.sink           job,
  mfq_result_if.source      result,
  mfq_cfg_if.sink           cfg
);
  import mfq_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0]   quantum_top;
  logic [TIME_W-1:0]   quantum_middle;
  logic [PERIOD_W-1:0] promote_period;

  // Latched item.
  logic              op_add;
  logic [LVL_W-1:0]  op_level;
  logic [TIME_W-1:0] op_burst;

  // Scheduler state.
  logic [PTR_W-1:0]   head  [NUM_LEVELS];
  logic [PTR_W-1:0]   tail  [NUM_LEVELS];
  logic [CNT_W-1:0]   count [NUM_LEVELS];
  entry_t             rd_data [NUM_LEVELS];
  logic [CLOCK_W-1:0] time_now;
  logic [SUM_W-1:0]   completion_total;
  logic [SUM_W-1:0]   waiting_total;
  logic [PERIOD_W-1:0] promote_counter;
  logic [CNT_W-1:0]   next_pid;

  // Working registers of the current item.
  logic [LVL_W-1:0]    sel_level;
  logic [TIME_W-1:0]   fin_orig;
  logic [CLOCK_W-1:0]  wait_val;
  logic [STATUS_W-1:0] res_status;
  logic [PID_W-1:0]    res_pid;
  logic [LVL_W-1:0]    res_from;
  logic [TIME_W-1:0]   res_run;
  logic [TIME_W-1:0]   res_rem;
  logic [OUTC_W-1:0]   res_outc;
  logic                out_valid;

  // Combinational helpers.
  logic               take;
  logic               has_job;
  logic               pid_free;
  logic [LVL_W-1:0]   first_level;
  logic [LVL_W-1:0]   add_level;
  entry_t             head_entry;
  logic [TIME_W-1:0]  quantum;
  logic               keep;
  logic [TIME_W-1:0]  run_val;
  logic               push_en;
  logic [LVL_W-1:0]   push_q;
  entry_t             push_entry;
  logic               pop_en;
  logic [LVL_W-1:0]   requeue_level;
  logic [OUTC_W-1:0]  requeue_outc;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W:0]  counter_inc;
  logic [CLOCK_W:0]   clock_sum;
  logic [SUM_W:0]     comp_sum;
  logic [SUM_W:0]     wait_sum;

  // Handshakes; nothing is accepted while reset is held.
  assign job.ready = cmd.idle && !rst;
  assign take      = job.valid && job.ready;
  assign cfg.ready = !rst;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_top    <= QUANTUM_TOP_RST;
      quantum_middle <= QUANTUM_MIDDLE_RST;
      promote_period <= PROMOTE_PERIOD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_QUANTUM_TOP:    quantum_top    <= cfg.data;
        CFG_QUANTUM_MIDDLE: quantum_middle <= cfg.data;
        CFG_PROMOTE_PERIOD: promote_period <= cfg.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (take) begin
      op_add   <= (job.cmd == CMD_ADD);
      op_level <= job.level;
      op_burst <= job.burst;
    end
  end

  // Queue selection in strict priority order.
  always_comb begin
    has_job     = 1'b1;
    first_level = LVL_FCFS;
    if (count[0] != '0)      first_level = LVL_TOP;
    else if (count[1] != '0) first_level = LVL_MIDDLE;
    else if (count[2] != '0) first_level = LVL_FCFS;
    else                     has_job = 1'b0;
  end

  assign pid_free  = (next_pid != CNT_W'(MAX_PROCESSES));
  assign add_level = (op_level == LVL_EXTRA) ? LVL_FCFS : op_level;

  // Head entry read in the previous cycle for the selected level.
  always_comb begin
    case (sel_level)
      LVL_TOP:    head_entry = rd_data[0];
      LVL_MIDDLE: head_entry = rd_data[1];
      default:    head_entry = rd_data[2];
    endcase
  end

  // Run decision for the popped job.
  assign quantum = (sel_level == LVL_TOP) ? quantum_top : quantum_middle;
  assign keep    = (sel_level != LVL_FCFS) && (head_entry.rem > quantum);
  assign run_val = keep ? quantum : head_entry.rem;

  // Promotion counter step with a zero period treated as one.
  assign period_eff  = (promote_period == '0) ? PERIOD_W'(1) : promote_period;
  assign counter_inc = {1'b0, promote_counter} + (PERIOD_W + 1)'(1);

  // Where an unfinished job goes next.
  always_comb begin
    if (sel_level == LVL_TOP) begin
      requeue_level = LVL_MIDDLE;
      requeue_outc  = OUTC_MIDDLE;
    end else if (promote_counter == '0) begin
      requeue_level = LVL_TOP;
      requeue_outc  = OUTC_PROMOTED;
    end else begin
      requeue_level = LVL_FCFS;
      requeue_outc  = OUTC_FCFS;
    end
  end

  // Push and pop requests; a queue never sees both in one cycle.
  always_comb begin
    push_en    = 1'b0;
    push_q     = add_level;
    push_entry = '{pid: next_pid[PID_W-1:0], rem: op_burst, orig: op_burst};
    if (cmd.exec && op_add && pid_free) begin
      push_en = 1'b1;
    end else if (cmd.apply && keep) begin
      push_en    = 1'b1;
      push_q     = requeue_level;
      push_entry = '{pid: head_entry.pid, rem: head_entry.rem - quantum,
                     orig: head_entry.orig};
    end
  end

  assign pop_en = cmd.exec && !op_add && has_job;

  // Queue memories and pointers.
  for (genvar q = 0; q < NUM_LEVELS; q++) begin : g_queue
    entry_t mem [MAX_PROCESSES];
    logic   push_here;
    logic   pop_here;

    assign push_here = push_en && (push_q == LVL_W'(q));
    assign pop_here  = pop_en && (first_level == LVL_W'(q));

    // Single write port at the tail; registered read at the head.
    always_ff @(posedge clk) begin
      if (push_here) mem[tail[q]] <= push_entry;
      rd_data[q] <= mem[head[q]];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        head[q]  <= '0;
        tail[q]  <= '0;
        count[q] <= '0;
      end else if (push_here) begin
        tail[q]  <= (tail[q] == PTR_W'(MAX_PROCESSES - 1)) ? '0 : tail[q] + PTR_W'(1);
        count[q] <= count[q] + CNT_W'(1);
      end else if (pop_here) begin
        head[q]  <= (head[q] == PTR_W'(MAX_PROCESSES - 1)) ? '0 : head[q] + PTR_W'(1);
        count[q] <= count[q] - CNT_W'(1);
      end
    end
  end

  // Saturating adders.
  assign clock_sum = {1'b0, time_now} + (CLOCK_W + 1)'(run_val);
  assign comp_sum  = {1'b0, completion_total} + (SUM_W + 1)'(time_now);
  assign wait_sum  = {1'b0, waiting_total} + (SUM_W + 1)'(wait_val);

  // Clock, sums, promotion counter and identifier counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now         <= '0;
      completion_total <= '0;
      waiting_total    <= '0;
      promote_counter  <= '0;
      next_pid         <= '0;
    end else begin
      if (cmd.exec && op_add && pid_free) next_pid <= next_pid + CNT_W'(1);
      if (cmd.apply) time_now <= clock_sum[CLOCK_W] ? '1 : clock_sum[CLOCK_W-1:0];
      if (cmd.apply && keep && (sel_level == LVL_MIDDLE)) begin
        promote_counter <= (counter_inc >= {1'b0, period_eff}) ? '0
                                                                : counter_inc[PERIOD_W-1:0];
      end
      if (cmd.sum1) completion_total <= comp_sum[SUM_W] ? '1 : comp_sum[SUM_W-1:0];
      if (cmd.sum2) waiting_total <= wait_sum[SUM_W] ? '1 : wait_sum[SUM_W-1:0];
    end
  end

  // Result fields of the current item.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sel_level <= first_level;
      res_run   <= '0;
      res_rem   <= '0;
      res_outc  <= OUTC_FINISHED;
      res_from  <= '0;
      res_pid   <= '0;
      if (op_add) begin
        if (pid_free) begin
          res_status <= ST_ADDED;
          res_pid    <= next_pid[PID_W-1:0];
        end else begin
          res_status <= ST_REJECTED;
        end
      end else if (has_job) begin
        res_status <= ST_DISPATCHED;
        res_from   <= first_level;
      end else begin
        res_status <= ST_EMPTY;
      end
    end
    if (cmd.apply) begin
      res_pid  <= head_entry.pid;
      res_run  <= run_val;
      res_rem  <= keep ? head_entry.rem - quantum : '0;
      res_outc <= keep ? requeue_outc : OUTC_FINISHED;
      fin_orig <= head_entry.orig;
    end
    // Waiting time of a finished job, clamped at zero.
    if (cmd.sum1) begin
      wait_val <= (time_now >= CLOCK_W'(fin_orig)) ? time_now - CLOCK_W'(fin_orig) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.status         <= res_status;
      result.pid            <= res_pid;
      result.from_level     <= res_from;
      result.slice_run      <= res_run;
      result.remaining      <= res_rem;
      result.outcome        <= res_outc;
      result.clock_now      <= time_now;
      result.completion_sum <= completion_total;
      result.waiting_sum    <= waiting_total;
      result.process_count  <= next_pid;
      result.all_empty      <= !has_job;
    end
  end

  assign result.valid = out_valid;

  // Status to the controller.
  always_comb begin
    stat.job_valid = job.valid;
    stat.is_add    = op_add;
    stat.has_job   = has_job;
    stat.finished  = !keep;
    stat.out_free  = !out_valid || result.ready;
  end

endmodule

`default_nettype wire
